>>> sv/rwa_pkg.sv
// Package: constants, types and the step-delta table for the absorption step unit.
package rwa_pkg;

  localparam int MaxAbsorbers = 64;
  localparam int MaxEmitters  = 64;
  localparam int CountWidth   = 14;
  localparam int StepLength   = 10;
  localparam int AbsW         = 6;
  localparam int EmW          = 6;
  localparam int CoordW       = 18;
  localparam int HitAddrW     = EmW + AbsW;

  localparam longint unsigned SineHalfPi = 64'd1686629713;
  localparam longint unsigned SineOne    = 64'd1073741824;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_LAUNCH = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_WALKING = 3'd1,
    ST_LEFT    = 3'd2,
    ST_ABSORB  = 3'd3,
    ST_NOWALK  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_UPPER  = 2'd0,
    CFG_LOWER  = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_COUNT  = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_READ
  } state_e;

  // Token carried along the chain of cells.
  typedef struct packed {
    logic                     vld;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } tok_t;

  // Result leaving the end of the chain.
  typedef struct packed {
    logic            vld;
    logic            hit;
    logic [AbsW-1:0] idx;
  } res_t;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Step delta for a quarter-turn angle code 0..256, in 1/256 units:
  // Q30 Taylor sine up to x^13, scaled by the step length, rounded half up.
  function automatic logic [11:0] quarter_delta(input logic [8:0] k);
    longint unsigned r, x, x2, term, scaled;
    longint          sum;
    r    = 64'(k) << 22;
    x    = (r * SineHalfPi) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int j = 1; j <= 6; j++) begin
      term = ((term * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
      if ((j & 1) == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(SineOne)) sum = longint'(SineOne);
    scaled = (64'(StepLength) * 64'd256 * 64'(sum) + (64'd1 << 29)) >> 30;
    return 12'(scaled);
  endfunction

endpackage

>>> sv/random_walker_absorption_step_unit.sv
// Top level: walker state, absorber cell chain and hit counter memory.
//
//  channel | signals                                   | direction
//  cmd     | start_i, busy_o, cmd_i .. threshold_i      | in
//  result  | done_o, status_o, hit_absorber_o, count_o  | out
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i, ... | in
//
// After reset a clearing pass zeroes all 4096 hit counters; busy is high.
// Load, launch, a step with no walker or out of the frame, and a read each pass S_DRAIN
// before the next acceptance; a read first passes S_READ, and a step inside the frame runs
// the 64-cell chain that the walker position travels, one cell per cycle, then S_UPDATE.
// The receiver cannot stall: done_o marks each result for one cycle.
module random_walker_absorption_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  cell_index_i,
  input  logic [5:0]  absorber_index_i,
  input  logic signed [17:0] pos_x_i,
  input  logic signed [17:0] pos_y_i,
  input  logic [9:0]  angle_i,
  input  logic [15:0] chance_i,
  input  logic [16:0] threshold_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [5:0]  hit_absorber_o,
  output logic [13:0] count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [25:0] cfg_data_i
);
  import rwa_pkg::*;

  state_e state_q, state_d;
  logic signed [CoordW-1:0] upper_q, lower_q, wx_q, wy_q;
  logic [25:0] r2_q;
  logic [6:0]  acnt_q;
  logic        alive_q;
  logic [EmW-1:0] wem_q;
  logic [16:0] wthr_q;
  logic [15:0] chance_q;
  logic [HitAddrW-1:0] clr_q;
  logic [CountWidth-1:0] mem [MaxEmitters*MaxAbsorbers];
  logic [CountWidth-1:0] rd_q;
  logic [HitAddrW-1:0] rd_addr;
  logic rd_en, wr_en, hit_q;
  logic [AbsW-1:0] hidx_q;
  logic signed [CoordW:0] dx, dy;
  logic signed [CoordW+1:0] sx, sy;
  logic [6:0] nabs;
  tok_t tok [MaxAbsorbers+1];
  res_t res [MaxAbsorbers+1];
  logic [2:0] st_q;
  logic [5:0] ho_q;
  logic [13:0] co_q;
  logic dn_q, rd_ok_q;
  logic go_step;

  function automatic logic left_out(input logic signed [CoordW+1:0] a,
                                    input logic signed [CoordW+1:0] b);
    return a > (CoordW+2)'(upper_q) || b > (CoordW+2)'(upper_q) ||
           a < (CoordW+2)'(lower_q) || b < (CoordW+2)'(lower_q);
  endfunction

  rwa_delta u_delta (.angle_i(angle_i), .dx_o(dx), .dy_o(dy));

  assign sx = (CoordW+2)'(wx_q) + (CoordW+2)'(dx);
  assign sy = (CoordW+2)'(wy_q) + (CoordW+2)'(dy);
  assign nabs = (acnt_q > 7'(MaxAbsorbers)) ? 7'(MaxAbsorbers) : acnt_q;
  assign busy_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Inject the new position into the chain when a step is accepted with a live walker inside the frame.
  assign go_step = start_i && !busy_o && cmd_i == CMD_STEP && alive_q && !left_out(sx, sy);

  assign tok[0] = '{vld: go_step, px: sx[CoordW-1:0], py: sy[CoordW-1:0]};
  assign res[0] = '{vld: go_step, hit: 1'b0, idx: '0};

  for (genvar g = 0; g < MaxAbsorbers; g++) begin : g_cell
    rwa_cell u_cell (
      .clk_i, .rst_ni,
      .load_i(start_i && !busy_o && cmd_i == CMD_LOAD && cell_index_i == AbsW'(g)),
      .ld_x_i(pos_x_i), .ld_y_i(pos_y_i),
      .en_i(7'(g) < nabs), .r2_i(r2_q), .my_idx_i(AbsW'(g)),
      .tok_i(tok[g]), .res_i(res[g]), .tok_o(tok[g+1]), .res_o(res[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          if (cmd_i == CMD_STEP && go_step) state_d = S_SCAN;
          else if (cmd_i == CMD_READ) state_d = S_READ;
          else state_d = S_DRAIN;
        end
      end
      S_SCAN:   if (res[MaxAbsorbers].vld) state_d = S_UPDATE;
      S_UPDATE: state_d = S_DRAIN;
      S_READ:   state_d = S_DRAIN;
      S_DRAIN:  state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign rd_en = (state_q == S_IDLE && start_i) || (state_q == S_SCAN);
  assign rd_addr = (state_q == S_SCAN) ? {wem_q, res[MaxAbsorbers].idx}
                                       : {cell_index_i, absorber_index_i};
  assign wr_en = (state_q == S_CLEAR) ||
                 (state_q == S_UPDATE && hit_q && rd_q != CountMax);

  // Counter memory: clearing pass, then saturating increment on a hit, and reads.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[state_q == S_CLEAR ? clr_q : {wem_q, hidx_q}] <=
      (state_q == S_CLEAR) ? '0 : rd_q + 1'b1;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Control, walker and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0;
      upper_q <= 18'sd121600; lower_q <= -18'sd6400; r2_q <= 26'd1638400; acnt_q <= '0;
      alive_q <= 1'b0; wx_q <= '0; wy_q <= '0; wem_q <= '0; wthr_q <= '0;
      dn_q <= 1'b0; st_q <= '0; ho_q <= '0; co_q <= '0; hit_q <= 1'b0; hidx_q <= '0;
      chance_q <= '0; rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dn_q <= 1'b0;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_UPPER:  upper_q <= cfg_data_i[17:0];
          CFG_LOWER:  lower_q <= cfg_data_i[17:0];
          CFG_RADIUS: r2_q <= cfg_data_i;
          CFG_COUNT:  acnt_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (start_i) begin
          st_q <= ST_DONE; ho_q <= '0; co_q <= '0;
          rd_ok_q <= 7'(cell_index_i) < 7'(MaxEmitters) && 7'(absorber_index_i) < 7'(MaxAbsorbers);
          chance_q <= chance_i;
          case (cmd_i)
            CMD_LAUNCH: begin
              alive_q <= 1'b1; wx_q <= pos_x_i; wy_q <= pos_y_i;
              wem_q <= cell_index_i; wthr_q <= threshold_i;
            end
            CMD_STEP: begin
              if (!alive_q) st_q <= ST_NOWALK;
              else begin
                wx_q <= sx[CoordW-1:0]; wy_q <= sy[CoordW-1:0];
                if (left_out(sx, sy)) begin
                  alive_q <= 1'b0; st_q <= ST_LEFT;
                end else st_q <= ST_WALKING;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          hit_q <= res[MaxAbsorbers].hit && ({1'b0, chance_q} < wthr_q);
          hidx_q <= res[MaxAbsorbers].idx;
        end
        S_UPDATE: if (hit_q) begin
          alive_q <= 1'b0; st_q <= ST_ABSORB; ho_q <= hidx_q;
        end
        S_READ: co_q <= rd_ok_q ? rd_q : '0;
        S_DRAIN: dn_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign done_o = dn_q;
  assign status_o = st_q;
  assign hit_absorber_o = ho_q;
  assign count_o = co_q;

  logic unused;
  assign unused = ^tok[MaxAbsorbers];

`ifndef SYNTH
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_absorb_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_ABSORB) |-> !alive_q) else $error("absorbed walker alive");
`endif
endmodule

>>> sv/rwa_delta.sv
// Step delta from an angle code: sign and quarter-turn lookup.
module rwa_delta (
  input  logic [9:0]                 angle_i,
  output logic signed [rwa_pkg::CoordW:0] dx_o,
  output logic signed [rwa_pkg::CoordW:0] dy_o
);
  import rwa_pkg::*;

  logic [11:0] tab [257];
  logic [9:0] ay;
  logic [8:0] kx, ky;
  logic [11:0] mx, my;

  // Build the quarter-turn table at elaboration.
  for (genvar k = 0; k <= 256; k++) begin : g_tab
    localparam logic [11:0] Val = quarter_delta(9'(k));
    assign tab[k] = Val;
  end

  // Cosine uses a quarter-turn offset; odd quadrants mirror the code.
  assign ay = angle_i + 10'd256;
  assign kx = angle_i[8] ? 9'(9'd256 - {1'b0, angle_i[7:0]}) : {1'b0, angle_i[7:0]};
  assign ky = ay[8] ? 9'(9'd256 - {1'b0, ay[7:0]}) : {1'b0, ay[7:0]};
  assign mx = tab[kx];
  assign my = tab[ky];
  assign dx_o = angle_i[9] ? -$signed({7'd0, mx}) : $signed({7'd0, mx});
  assign dy_o = ay[9] ? -$signed({7'd0, my}) : $signed({7'd0, my});
endmodule

>>> sv/rwa_cell.sv
// One absorber cell: holds a disk center and tests the passing walker position.
module rwa_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic signed [rwa_pkg::CoordW-1:0] ld_x_i,
  input  logic signed [rwa_pkg::CoordW-1:0] ld_y_i,
  input  logic                      en_i,
  input  logic [25:0]               r2_i,
  input  logic [rwa_pkg::AbsW-1:0]  my_idx_i,
  input  rwa_pkg::tok_t             tok_i,
  input  rwa_pkg::res_t             res_i,
  output rwa_pkg::tok_t             tok_o,
  output rwa_pkg::res_t             res_o
);
  import rwa_pkg::*;

  logic signed [CoordW-1:0] cx_q, cy_q, px_q, py_q;
  logic signed [CoordW+1:0] dx, dy;
  logic [39:0] d2;
  logic in_disk;
  logic tvld_q, rvld_q, hit_q;
  logic [AbsW-1:0] idx_q;

  // Hold the disk center.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cx_q <= ld_x_i;
      cy_q <= ld_y_i;
    end
  end

  assign dx = (CoordW+2)'(tok_i.px) - (CoordW+2)'(cx_q);
  assign dy = (CoordW+2)'(tok_i.py) - (CoordW+2)'(cy_q);
  assign d2 = 40'(dx * dx) + 40'(dy * dy);
  assign in_disk = en_i && (d2 < {14'd0, r2_i});

  // Advance token and first-hit result one cell per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvld_q <= 1'b0;
      rvld_q <= 1'b0;
    end else begin
      tvld_q <= tok_i.vld;
      rvld_q <= res_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= tok_i.px;
    py_q <= tok_i.py;
    if (res_i.hit) begin
      hit_q <= 1'b1;
      idx_q <= res_i.idx;
    end else begin
      hit_q <= in_disk;
      idx_q <= my_idx_i;
    end
  end

  assign tok_o = '{vld: tvld_q, px: px_q, py: py_q};
  assign res_o = '{vld: rvld_q, hit: hit_q, idx: idx_q};
endmodule
